[hdl/velocity_pid_normalized_defines.svh]
// ----------------------------------------------------------------------------
// velocity_pid_normalized_defines.svh
// Assertion macros shared by the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_PID_NORMALIZED_DEFINES_SVH
`define VELOCITY_PID_NORMALIZED_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define VPID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define VPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vpid_pkg.sv]
// ----------------------------------------------------------------------------
// vpid_pkg
// Types and constants of the velocity-form PID controller.
// ----------------------------------------------------------------------------
package vpid_pkg;

  localparam int OUT_MIN_DEF = 0;
  localparam int OUT_MAX_DEF = 4095;

  localparam int CfgW    = 24;
  localparam int CfgIdxW = 3;
  localparam int RawW    = 16;
  localparam int NormW   = 17;
  localparam int GainW   = 24;

  // Q1.16 one
  localparam logic [NormW-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_P,
    MODE_PI,
    MODE_PID
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE,
    REG_KP_GAIN,
    REG_KI_GAIN,
    REG_KD_GAIN,
    REG_IN_MIN,
    REG_IN_MAX,
    REG_FB_MIN,
    REG_FB_MAX
  } cfg_reg_e;

  typedef struct packed {
    logic signed [RawW-1:0] setpoint_raw;
    logic signed [RawW-1:0] feedback_raw;
  } in_req_t;

  typedef struct packed {
    logic signed [RawW-1:0] drive_out;
    logic [NormW-1:0]       drive_norm;
  } out_res_t;

endpackage

[hdl/velocity_pid_normalized.sv]
// ----------------------------------------------------------------------------
// velocity_pid_normalized
// Velocity-form PID controller on normalized Q1.16 values, one shared
// divider step and one shared 19x24 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  ---------+-----------+------------------------------------------
//  in       | request   | in_valid_i, in_stall_o, in_data_i
//  out      | result    | out_valid_o, out_stall_i, out_data_o
//  cfg      | write     | cfg_we_i, cfg_idx_i, cfg_data_i
//
//  A request runs two normalizations, each of setup, check and 16 restoring
//  divide steps, then the three gain products, clamp and output scaling. A
//  value that saturates or has a zero span skips its divide steps. In idle mode
//  a request skips straight to output scaling with a zero drive.
//  in_stall_o is high while a request is in work; the result sits in an
//  output register, so a new request is taken while it waits downstream.
//  Reset is asynchronous and active low; no clearing pass.
// ----------------------------------------------------------------------------
`include "velocity_pid_normalized_defines.svh"

module velocity_pid_normalized #(
  parameter int OUT_MIN = vpid_pkg::OUT_MIN_DEF,
  parameter int OUT_MAX = vpid_pkg::OUT_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vpid_pkg::in_req_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vpid_pkg::out_res_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [vpid_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vpid_pkg::CfgW-1:0]     cfg_data_i
);
  import vpid_pkg::*;

  localparam int                     SPAN     = OUT_MAX - OUT_MIN;
  localparam logic signed [GainW-1:0] SpanGain = GainW'(SPAN);
  localparam logic [RawW-1:0]        OutMinW  = RawW'(OUT_MIN);
  localparam int                     DiffW    = NormW + 2;
  localparam int                     ProdW    = DiffW + GainW;
  localparam int                     AccW     = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NSET,
    ST_NCHK,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_SMUL,
    ST_SADD,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    T_P,
    T_I,
    T_D
  } term_e;

  // configuration
  mode_e                   mode_q;
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic signed [RawW-1:0]  in_min_q, in_max_q, fb_min_q, fb_max_q;

  // sequencer and datapath
  state_e                  state_q;
  term_e                   term_q;
  logic                    sel_q;
  logic signed [RawW-1:0]  sp_raw_q, fb_raw_q;
  logic signed [NormW-1:0] num_q, den_q;
  logic [RawW-1:0]         rem_q, dvs_q, quo_q;
  logic [3:0]              cnt_q;
  logic [NormW-1:0]        sp_n_q, pv_n_q;
  logic signed [DiffW-1:0] diff_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic [NormW-1:0]        drive_q, drive_prev_q, pv_prev_q, pv_older_q;
  logic [RawW-1:0]         scaled_q;
  out_res_t                out_q;
  logic                    out_valid_q;

  // combinational helpers
  logic signed [NormW-1:0] num_c, den_c;
  logic [NormW-1:0]        mag_n, mag_d;
  logic                    norm_zero;
  logic [RawW:0]           rem2;
  logic                    div_ge;
  logic [RawW-1:0]         rem_nx;
  logic [RawW-1:0]         quo_nx;
  logic signed [DiffW-1:0] sp19, pv19, pvp19, pvo19;
  logic signed [DiffW-1:0] diff_p, diff_i, diff_d;
  logic signed [GainW-1:0] gain_sel;
  logic signed [DiffW-1:0] mul_a;
  logic signed [GainW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_y;
  logic signed [AccW-1:0]  term_v;
  logic                    out_load;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      in_min_q <= '0;
      in_max_q <= 16'sh7FFF;
      fb_min_q <= '0;
      fb_max_q <= 16'sh7FFF;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:    mode_q   <= mode_e'(cfg_data_i[1:0]);
        REG_KP_GAIN: kp_q     <= signed'(cfg_data_i);
        REG_KI_GAIN: ki_q     <= signed'(cfg_data_i);
        REG_KD_GAIN: kd_q     <= signed'(cfg_data_i);
        REG_IN_MIN:  in_min_q <= signed'(cfg_data_i[RawW-1:0]);
        REG_IN_MAX:  in_max_q <= signed'(cfg_data_i[RawW-1:0]);
        REG_FB_MIN:  fb_min_q <= signed'(cfg_data_i[RawW-1:0]);
        REG_FB_MAX:  fb_max_q <= signed'(cfg_data_i[RawW-1:0]);
        default: ;
      endcase
    end
  end

  // normalization front end: x - min and max - min, 17 bit signed
  always_comb begin
    if (sel_q) begin
      num_c = NormW'(fb_raw_q) - NormW'(fb_min_q);
      den_c = NormW'(fb_max_q) - NormW'(fb_min_q);
    end else begin
      num_c = NormW'(sp_raw_q) - NormW'(in_min_q);
      den_c = NormW'(in_max_q) - NormW'(in_min_q);
    end
    mag_n     = num_q[NormW-1] ? NormW'(-num_q) : NormW'(num_q);
    mag_d     = den_q[NormW-1] ? NormW'(-den_q) : NormW'(den_q);
    norm_zero = (num_q == '0) || (den_q == '0) || (num_q[NormW-1] != den_q[NormW-1]);
  end

  // one restoring divide step; remainder always stays below the divisor
  always_comb begin
    rem2   = {rem_q, 1'b0};
    div_ge = rem2 >= {1'b0, dvs_q};
    rem_nx = div_ge ? RawW'(rem2 - {1'b0, dvs_q}) : rem2[RawW-1:0];
    quo_nx = {quo_q[RawW-2:0], div_ge};
  end

  // differences, gain select and the shared multiplier
  always_comb begin
    sp19   = signed'(DiffW'(sp_n_q));
    pv19   = signed'(DiffW'(pv_n_q));
    pvp19  = signed'(DiffW'(pv_prev_q));
    pvo19  = signed'(DiffW'(pv_older_q));
    diff_p = pv19 - pvp19;
    diff_i = sp19 - pv19;
    diff_d = pv19 - (pvp19 <<< 1) + pvo19;

    case (term_q)
      T_P:     gain_sel = kp_q;
      T_I:     gain_sel = ((mode_q == MODE_PI) || (mode_q == MODE_PID)) ? ki_q : '0;
      T_D:     gain_sel = (mode_q == MODE_PID) ? kd_q : '0;
      default: gain_sel = '0;
    endcase

    if (state_q == ST_SMUL) begin
      mul_a = signed'(DiffW'(drive_q));
      mul_b = SpanGain;
    end else begin
      mul_a = diff_q;
      mul_b = gain_sel;
    end
    mul_y  = ProdW'(mul_a) * ProdW'(mul_b);
    // floor to Q.16
    term_v = AccW'(signed'(prod_q[ProdW-1:16]));
  end

  // result moves into the output register when that register is free
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      term_q       <= T_P;
      sel_q        <= 1'b0;
      cnt_q        <= '0;
      drive_prev_q <= '0;
      pv_prev_q    <= '0;
      pv_older_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sp_raw_q <= in_data_i.setpoint_raw;
            fb_raw_q <= in_data_i.feedback_raw;
            sel_q    <= 1'b0;
            if (mode_q == MODE_IDLE) begin
              drive_q <= '0;
              state_q <= ST_SMUL;
            end else begin
              state_q <= ST_NSET;
            end
          end
        end
        ST_NSET: begin
          num_q   <= num_c;
          den_q   <= den_c;
          state_q <= ST_NCHK;
        end
        ST_NCHK: begin
          if (norm_zero || (mag_n >= mag_d)) begin
            // opposite signs or zero span give 0, a ratio of one or more saturates
            if (sel_q) begin
              pv_n_q  <= norm_zero ? '0 : ONE_Q16;
              term_q  <= T_P;
              state_q <= ST_DIFF;
            end else begin
              sp_n_q  <= norm_zero ? '0 : ONE_Q16;
              sel_q   <= 1'b1;
              state_q <= ST_NSET;
            end
          end else begin
            rem_q   <= mag_n[RawW-1:0];
            dvs_q   <= mag_d[RawW-1:0];
            quo_q   <= '0;
            cnt_q   <= 4'(RawW - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            if (sel_q) begin
              pv_n_q  <= {1'b0, quo_nx};
              term_q  <= T_P;
              state_q <= ST_DIFF;
            end else begin
              sp_n_q  <= {1'b0, quo_nx};
              sel_q   <= 1'b1;
              state_q <= ST_NSET;
            end
          end
        end
        ST_DIFF: begin
          diff_q  <= diff_p;
          acc_q   <= signed'(AccW'(drive_prev_q));
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= mul_y;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          case (term_q)
            T_P: begin
              acc_q   <= acc_q - term_v;
              diff_q  <= diff_i;
              term_q  <= T_I;
              state_q <= ST_MUL;
            end
            T_I: begin
              acc_q   <= acc_q + term_v;
              diff_q  <= diff_d;
              term_q  <= T_D;
              state_q <= ST_MUL;
            end
            default: begin
              acc_q   <= acc_q - term_v;
              state_q <= ST_CLAMP;
            end
          endcase
        end
        ST_CLAMP: begin
          if (acc_q[AccW-1]) begin
            drive_q      <= '0;
            drive_prev_q <= '0;
          end else if (acc_q > signed'(AccW'(ONE_Q16))) begin
            drive_q      <= ONE_Q16;
            drive_prev_q <= ONE_Q16;
          end else begin
            drive_q      <= acc_q[NormW-1:0];
            drive_prev_q <= acc_q[NormW-1:0];
          end
          pv_older_q <= pv_prev_q;
          pv_prev_q  <= pv_n_q;
          state_q    <= ST_SMUL;
        end
        ST_SMUL: begin
          prod_q  <= mul_y;
          state_q <= ST_SADD;
        end
        ST_SADD: begin
          scaled_q <= OutMinW + prod_q[31:16];
          state_q  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            out_q.drive_out  <= signed'(scaled_q);
            out_q.drive_norm <= drive_q;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VPID_ASSERT(a_div_rem, (state_q != ST_DIV) || (rem_q < dvs_q), "divide remainder not below divisor")
  `VPID_ASSERT(a_drive_unit, drive_prev_q <= ONE_Q16, "stored drive above one")
  `VPID_ASSERT(a_idle_zero, (state_q != ST_FINISH) || (mode_q != MODE_IDLE) || (drive_q == '0), "idle mode drive not zero")
  `VPID_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != ST_IDLE, "request taken but sequencer idle")

endmodule
